@@ rtl/core/mcot_pkg.sv @@
// Shared constants and codes for the multi-channel one-shot trigger bank.
// Depends on nothing; every other file in rtl/core imports it.
package mcot_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int TICK_WIDTH_DEF   = 16;

    localparam int CHANNEL_W   = 3;
    localparam int DELAY_W     = 16;
    localparam int MAX_RESULTS = 8;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

endpackage

@@ rtl/core/multi_channel_one_shot_trigger.sv @@
// Top level of the multi-channel one-shot trigger bank: sequencer, armed flags,
// shared decrement/zero-test unit and result register. Uses mcot_pkg, mcot_count_ram.
//
//   transaction   handshake        payload
//   command       start / busy     op, channel, delay_ticks, arm
//   result        strobe           fired_channel, last
//
// A set command completes while the sequencer stays idle and leaves busy low.
// A tick command runs a scan in which one shared decrementer walks the
// count memory one channel per cycle behind its registered read port, then the
// flush state emits the held result, if any. Results come out one per cycle at most.
// Reset clears the armed flags and the sequencer; counts are not cleared.
// The receiver cannot stall; each result stands on the ports for one cycle.
module multi_channel_one_shot_trigger #(
    parameter int NUM_CHANNELS = mcot_pkg::NUM_CHANNELS_DEF,
    parameter int TICK_WIDTH   = mcot_pkg::TICK_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           op,
    input  logic [mcot_pkg::CHANNEL_W-1:0] channel,
    input  logic [mcot_pkg::DELAY_W-1:0]   delay_ticks,
    input  logic                           arm,
    output logic                           strobe,
    output logic [mcot_pkg::CHANNEL_W-1:0] fired_channel,
    output logic                           last
);

    import mcot_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [NUM_CHANNELS-1:0] armed_reg, armed_next;
    logic [CNT_W-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                   p1_vld_reg, p1_vld_next;
    logic [IDX_W-1:0]       p1_idx_reg, p1_idx_next;
    logic [RES_CNT_W-1:0]   count_reg, count_next;
    logic                   pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic                   strobe_reg, strobe_next;
    logic [CHANNEL_W-1:0]   fired_reg, fired_next;
    logic                   last_reg, last_next;

    logic                  accept;
    logic [31:0]           ch_ext;
    logic [31:0]           delay_ext;
    logic [31:0]           pend_ext;
    logic                  ch_ok;
    logic                  issue;
    logic [TICK_WIDTH-1:0] rd_data;
    logic [TICK_WIDTH-1:0] dec_val;
    logic                  fire;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [TICK_WIDTH-1:0] wr_data;

    assign accept    = start && (state_reg == ST_IDLE);
    assign ch_ext    = 32'(channel);
    assign delay_ext = 32'(delay_ticks);
    assign pend_ext  = 32'(pend_idx_reg);
    assign ch_ok     = ch_ext < 32'(NUM_CHANNELS);
    assign issue     = (state_reg == ST_SCAN) && (rd_cnt_reg < CNT_W'(NUM_CHANNELS));

    assign dec_val = (rd_data != '0) ? (rd_data - TICK_WIDTH'(1)) : rd_data;
    assign fire    = p1_vld_reg && armed_reg[p1_idx_reg] && (dec_val == '0)
                     && (count_reg < RES_CNT_W'(MAX_RESULTS));

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = p1_idx_reg;
        wr_data = dec_val;
        if (accept && (op == OP_SET) && ch_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = ch_ext[IDX_W-1:0];
            wr_data = delay_ext[TICK_WIDTH-1:0];
        end
        else if (p1_vld_reg)
        begin
            wr_en = 1'b1;
        end
    end

    mcot_count_ram #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TICK_WIDTH   (TICK_WIDTH),
        .IDX_W        (IDX_W)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        armed_next    = armed_reg;
        rd_cnt_next   = rd_cnt_reg;
        p1_vld_next   = 1'b0;
        p1_idx_next   = rd_cnt_reg[IDX_W-1:0];
        count_next    = count_reg;
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;
        strobe_next   = 1'b0;
        fired_next    = fired_reg;
        last_next     = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_SET)
                    begin
                        if (ch_ok)
                        begin
                            armed_next[ch_ext[IDX_W-1:0]] = arm;
                        end
                    end
                    else
                    begin
                        rd_cnt_next   = '0;
                        count_next    = '0;
                        pend_vld_next = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                    p1_vld_next = 1'b1;
                end
                if (fire)
                begin
                    armed_next[p1_idx_reg] = 1'b0;
                    count_next             = count_reg + RES_CNT_W'(1);
                    pend_vld_next          = 1'b1;
                    pend_idx_next          = p1_idx_reg;
                    if (pend_vld_reg)
                    begin
                        strobe_next = 1'b1;
                        fired_next  = pend_ext[CHANNEL_W-1:0];
                        last_next   = 1'b0;
                    end
                end
                if (p1_vld_reg && (p1_idx_reg == IDX_W'(NUM_CHANNELS - 1)))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (pend_vld_reg)
                begin
                    strobe_next = 1'b1;
                    fired_next  = pend_ext[CHANNEL_W-1:0];
                    last_next   = 1'b1;
                end
                pend_vld_next = 1'b0;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            armed_reg    <= '0;
            rd_cnt_reg   <= '0;
            p1_vld_reg   <= 1'b0;
            count_reg    <= '0;
            pend_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            armed_reg    <= armed_next;
            rd_cnt_reg   <= rd_cnt_next;
            p1_vld_reg   <= p1_vld_next;
            count_reg    <= count_next;
            pend_vld_reg <= pend_vld_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_idx_reg   <= p1_idx_next;
        pend_idx_reg <= pend_idx_next;
        fired_reg    <= fired_next;
        last_reg     <= last_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign strobe        = strobe_reg;
    assign fired_channel = fired_reg;
    assign last          = last_reg;

    a_tick_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_TICK)) |=> busy)
        else $error("tick transaction did not start a scan");

    a_set_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_SET)) |=> !busy)
        else $error("set transaction left the block busy");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RES_CNT_W'(MAX_RESULTS))
        else $error("result count above capacity");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !pend_vld_reg)
        else $error("held result left behind after tick");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("result after last marker");

endmodule

@@ rtl/core/mcot_count_ram.sv @@
// Count memory of the trigger bank: one write port, one read port, registered read data.
// Depends on mcot_pkg for default sizes.
module mcot_count_ram #(
    parameter int NUM_CHANNELS = mcot_pkg::NUM_CHANNELS_DEF,
    parameter int TICK_WIDTH   = mcot_pkg::TICK_WIDTH_DEF,
    parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [TICK_WIDTH-1:0] wr_data,
    input  logic [IDX_W-1:0]      rd_addr,
    output logic [TICK_WIDTH-1:0] rd_data
);

    import mcot_pkg::*;

    logic [TICK_WIDTH-1:0] mem [NUM_CHANNELS];
    logic [TICK_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ test/mcot_fire_checker.sv @@
// Watches the command and result ports of the one-shot trigger bank, predicts which channels fire
// on every tick and compares each strobed result against the oldest prediction.
// Depends on mcot_pkg.
module mcot_fire_checker #(
    parameter int NUM_CHANNELS = mcot_pkg::NUM_CHANNELS_DEF,
    parameter int TICK_WIDTH   = mcot_pkg::TICK_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           op,
    input  logic [mcot_pkg::CHANNEL_W-1:0] channel,
    input  logic [mcot_pkg::DELAY_W-1:0]   delay_ticks,
    input  logic                           arm,
    input  logic                           strobe,
    input  logic [mcot_pkg::CHANNEL_W-1:0] fired_channel,
    input  logic                           last,
    output int                             pending,
    output int                             errors
);

    timeunit 1ns;
    timeprecision 1ps;

    import mcot_pkg::*;

    typedef struct packed {
        logic [CHANNEL_W-1:0] ch;
        logic                 last;
    } fire_t;

    fire_t                 fire_queue[$];
    logic [TICK_WIDTH-1:0] ticks_left[NUM_CHANNELS];
    logic                  armed_flag[NUM_CHANNELS];
    int                    mismatch_count;

    task automatic clear_bank();
        int k;
        for (k = 0; k < NUM_CHANNELS; k++)
        begin
            ticks_left[k] = '0;
            armed_flag[k] = 1'b0;
        end
    endtask

    task automatic forecast_command(input logic cmd_op, input logic [CHANNEL_W-1:0] ch,
                                    input logic [DELAY_W-1:0] ticks, input logic arm_in);
        int    k;
        int    fired;
        fire_t f;
        fired = 0;
        if (cmd_op == OP_SET)
        begin
            if (ch < NUM_CHANNELS)
            begin
                ticks_left[ch] = ticks[TICK_WIDTH-1:0];
                armed_flag[ch] = arm_in;
            end
        end
        else
        begin
            for (k = 0; k < NUM_CHANNELS; k++)
            begin
                if (ticks_left[k] != '0)
                    ticks_left[k] = ticks_left[k] - 1'b1;
            end
            for (k = 0; k < NUM_CHANNELS; k++)
            begin
                if (fired < MAX_RESULTS && armed_flag[k] && ticks_left[k] == '0)
                begin
                    armed_flag[k] = 1'b0;
                    f.ch = k[CHANNEL_W-1:0];
                    f.last = 1'b0;
                    fire_queue.push_back(f);
                    fired++;
                end
            end
            // mark the final fire of this tick
            if (fired > 0)
            begin
                f = fire_queue.pop_back();
                f.last = 1'b1;
                fire_queue.push_back(f);
            end
        end
    endtask

    task automatic check_fire();
        fire_t want;
        if (fire_queue.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, actual channel %0d last %0b",
                     $time, fired_channel, last);
            mismatch_count++;
        end
        else
        begin
            want = fire_queue.pop_front();
            if (fired_channel !== want.ch || last !== want.last)
            begin
                $display("%0t: result mismatch: expected channel %0d last %0b, actual channel %0d last %0b",
                         $time, want.ch, want.last, fired_channel, last);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_bank();
            fire_queue.delete();
            mismatch_count = 0;
            pending <= 0;
            errors <= 0;
        end
        else
        begin
            if (strobe)
                check_fire();
            if (start && !busy)
                forecast_command(op, channel, delay_ticks, arm);
            pending <= fire_queue.size();
            errors <= mismatch_count;
        end
    end

endmodule

@@ test/multi_channel_one_shot_trigger_test.sv @@
// Top of the trigger bank testbench: clock, reset, directed and random commands, verdict.
// Depends on mcot_pkg, multi_channel_one_shot_trigger and mcot_fire_checker.
module multi_channel_one_shot_trigger_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mcot_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 100;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 op;
    logic [CHANNEL_W-1:0] channel;
    logic [DELAY_W-1:0]   delay_ticks;
    logic                 arm;
    logic                 strobe;
    logic [CHANNEL_W-1:0] fired_channel;
    logic                 last;
    int                   pending;
    int                   errors;
    int                   stall_cycles = 0;

    multi_channel_one_shot_trigger u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .channel       (channel),
        .delay_ticks   (delay_ticks),
        .arm           (arm),
        .strobe        (strobe),
        .fired_channel (fired_channel),
        .last          (last)
    );

    mcot_fire_checker u_fire_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .channel       (channel),
        .delay_ticks   (delay_ticks),
        .arm           (arm),
        .strobe        (strobe),
        .fired_channel (fired_channel),
        .last          (last),
        .pending       (pending),
        .errors        (errors)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("multi_channel_one_shot_trigger_test: errors");
                $finish;
            end
        end
    end

    task automatic issue_command(input logic cmd_op, input logic [CHANNEL_W-1:0] ch,
                                 input logic [DELAY_W-1:0] ticks, input logic arm_in);
        start <= 1'b1;
        op <= cmd_op;
        channel <= ch;
        delay_ticks <= ticks;
        arm <= arm_in;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic issue_tick();
        issue_command(OP_TICK, CHANNEL_W'($urandom), DELAY_W'($urandom), 1'($urandom));
    endtask

    task automatic idle_sender(input int cycles);
        start <= 1'b0;
        op <= 1'($urandom);
        channel <= CHANNEL_W'($urandom);
        delay_ticks <= DELAY_W'($urandom);
        arm <= 1'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic issue_random_item();
        logic [DELAY_W-1:0] ticks;
        if ($urandom_range(99) < 40)
            issue_tick();
        else
        begin
            // keep most delays short so channels actually fire
            if ($urandom_range(99) < 10)
                ticks = DELAY_W'($urandom);
            else
                ticks = DELAY_W'($urandom_range(6));
            issue_command(OP_SET, CHANNEL_W'($urandom), ticks, $urandom_range(99) < 80);
        end
    endtask

    initial
    begin
        int i;
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_SET;
        channel = '0;
        delay_ticks = '0;
        arm = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_command(OP_SET, 3'd0, 16'd0, 1'b1);
        issue_tick();
        issue_command(OP_TICK, 3'd7, 16'hFFFF, 1'b1);
        issue_command(OP_SET, 3'd7, 16'hFFFF, 1'b1);
        issue_command(OP_SET, 3'd3, 16'd1, 1'b1);
        issue_command(OP_SET, 3'd5, 16'd2, 1'b0);
        issue_command(OP_SET, 3'd1, 16'd2, 1'b1);
        issue_command(OP_TICK, 3'd0, 16'h0000, 1'b0);
        issue_tick();
        issue_command(OP_SET, 3'd2, 16'hAAAA, 1'b1);
        issue_command(OP_SET, 3'd2, 16'h5555, 1'b0);
        for (i = 0; i < 8; i++)
            issue_command(OP_SET, CHANNEL_W'(i), 16'd0, 1'b1);
        issue_tick();
        issue_command(OP_SET, 3'd6, 16'd0, 1'b0);
        issue_tick();

        // hold off until every fire has been reported
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || busy);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ((i < 40 || i >= 70) && $urandom_range(99) < 14)
                idle_sender($urandom_range(1, 6));
            issue_random_item();
        end

        start <= 1'b0;
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (NUM_CHANNELS_DEF + 6) @(posedge clk);

        if (errors == 0)
            $display("multi_channel_one_shot_trigger_test: clean");
        else
            $display("multi_channel_one_shot_trigger_test: errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/mcot_pkg.sv
rtl/core/mcot_count_ram.sv
rtl/core/multi_channel_one_shot_trigger.sv
test/mcot_fire_checker.sv
test/multi_channel_one_shot_trigger_test.sv
